// ===== rtl/qfe_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qfe_pkg
// Shared codes and widths for the quotient filter engine.
// ----------------------------------------------------------------------------
package qfe_pkg;

   // request kinds carried on req_tuser
   localparam logic [1:0] OP_INSERT = 2'd0;
   localparam logic [1:0] OP_LOOKUP = 2'd1;
   localparam logic [1:0] OP_REMOVE = 2'd2;

   // slot flag bit positions, remainder sits above them
   localparam int FLAG_OCC   = 0;
   localparam int FLAG_CONT  = 1;
   localparam int FLAG_SHIFT = 2;
   localparam int FLAG_BITS  = 3;

   localparam int HASH_W  = 64;
   localparam int OP_W    = 2;
   localparam int COUNT_W = 11;
   localparam int RSP_W   = 16;

   typedef logic [OP_W-1:0] op_type;

endpackage

// ===== rtl/qfe_slot_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qfe_slot_ram
// Slot table storage: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module qfe_slot_ram #(
   parameter int AW = 10,
   parameter int DW = 11
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [DW-1:0] wr_data,
   input  logic [AW-1:0] rd_addr,
   output logic [DW-1:0] rd_data
);

   logic [DW-1:0] mem [(1 << AW)];
   logic [DW-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/quotient_filter_engine.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quotient_filter_engine
// Approximate membership filter over a 2^QBITS slot table.
// ----------------------------------------------------------------------------
// Usage:
//   req channel: tuser carries the op (insert, lookup, remove), tdata the
//   64-bit hash. rsp channel: one transaction per request with the answer
//   bit and the entry count after the request.
//   A request is worked on by a sequencer that walks the slot table one
//   slot at a time through a RAM with one write and one read port; every
//   slot visit puts the address out and takes the registered data back.
//   A request goes through the back walk to the cluster head, the run
//   scan, and the shift or slide through the rest of the cluster; a
//   request with an empty home slot finishes without these steps.
//   req_tready is high only while no request is being worked on.
//   The result sits in an output register; the next request is accepted
//   while it waits. If the receiver stalls, the following request runs
//   to its end and then holds until the register frees.
//   After reset the table is cleared one slot a cycle through all 2^QBITS
//   slots, during which req_tready stays low.
// ----------------------------------------------------------------------------
module quotient_filter_engine
   import qfe_pkg::*;
#(
   parameter int QBITS = 10,
   parameter int RBITS = 8
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [HASH_W-1:0] req_tdata,   // hash
   input  logic [OP_W-1:0]   req_tuser,   // op
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [RSP_W-1:0]  rsp_tdata    // answer, entry_count, zero fill
);

   localparam int IW    = QBITS;
   localparam int EW    = RBITS + FLAG_BITS;
   localparam int CW    = QBITS + 1;
   localparam int TSIZE = 1 << QBITS;

   localparam logic [4:0] S_CLEAR  = 5'd0;
   localparam logic [4:0] S_IDLE   = 5'd1;
   localparam logic [4:0] S_T_RD   = 5'd2;
   localparam logic [4:0] S_T      = 5'd3;
   localparam logic [4:0] S_LB_RD  = 5'd4;
   localparam logic [4:0] S_LB     = 5'd5;
   localparam logic [4:0] S_LR     = 5'd6;
   localparam logic [4:0] S_NR_RD  = 5'd7;
   localparam logic [4:0] S_NR     = 5'd8;
   localparam logic [4:0] S_NO_RD  = 5'd9;
   localparam logic [4:0] S_NO     = 5'd10;
   localparam logic [4:0] S_SC_RD  = 5'd11;
   localparam logic [4:0] S_SC     = 5'd12;
   localparam logic [4:0] S_SH_RD  = 5'd13;
   localparam logic [4:0] S_SH     = 5'd14;
   localparam logic [4:0] S_RN_RD  = 5'd15;
   localparam logic [4:0] S_RN     = 5'd16;
   localparam logic [4:0] S_SOC_RD = 5'd17;
   localparam logic [4:0] S_SOC    = 5'd18;
   localparam logic [4:0] S_SO_RD  = 5'd19;
   localparam logic [4:0] S_SO     = 5'd20;
   localparam logic [4:0] S_SQ_RD  = 5'd21;
   localparam logic [4:0] S_SQ     = 5'd22;
   localparam logic [4:0] S_SOW    = 5'd23;
   localparam logic [4:0] S_FX_RD  = 5'd24;
   localparam logic [4:0] S_FX     = 5'd25;
   localparam logic [4:0] S_DONE   = 5'd26;

   logic [4:0]         state_ff, state_in;
   op_type             op_ff, op_in;
   logic [IW-1:0]      q_ff, q_in;
   logic [RBITS-1:0]   r_ff, r_in;
   logic [CW-1:0]      count_ff, count_in;
   logic [EW-1:0]      t_ff, t_in;
   logic [IW-1:0]      b_ff, b_in;
   logic [IW-1:0]      s_ff, s_in;
   logic [IW-1:0]      start_ff, start_in;
   logic               first_ff, first_in;
   logic [EW-1:0]      cur_ff, cur_in;
   logic [EW-1:0]      nx_ff, nx_in;
   logic [IW-1:0]      quot_ff, quot_in;
   logic [IW-1:0]      found_ff, found_in;
   logic               head_ff, head_in;
   logic               ans_ff, ans_in;
   logic [IW-1:0]      clr_ff, clr_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_ans_ff, rsp_ans_in;
   logic [COUNT_W-1:0] rsp_cnt_ff, rsp_cnt_in;

   logic               wr_en;
   logic [IW-1:0]      wr_addr;
   logic [EW-1:0]      wr_data;
   logic [IW-1:0]      rd_addr;
   logic [EW-1:0]      rd;

   logic [EW-1:0]      ent;
   logic [EW-1:0]      prev;
   logic [EW-1:0]      upd;
   logic [IW-1:0]      s_inc;
   logic               out_free;

   qfe_slot_ram #(
      .AW (IW),
      .DW (EW)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd)
   );

   function automatic logic is_empty(input logic [EW-1:0] x);
      return x[FLAG_BITS-1:0] == '0;
   endfunction

   function automatic logic is_run_head(input logic [EW-1:0] x);
      return !x[FLAG_CONT] && (x[FLAG_OCC] || x[FLAG_SHIFT]);
   endfunction

   function automatic logic is_cluster_head(input logic [EW-1:0] x);
      return x[FLAG_OCC] && !x[FLAG_CONT] && !x[FLAG_SHIFT];
   endfunction

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {(RSP_W - COUNT_W - 1)'(0), rsp_cnt_ff, rsp_ans_ff};
   assign s_inc      = s_ff + IW'(1);
   assign out_free   = !rsp_valid_ff || rsp_tready;

   always_comb begin
      unique case (state_ff)
         S_T_RD:   rd_addr = q_ff;
         S_LB_RD:  rd_addr = b_ff;
         S_NR_RD:  rd_addr = s_ff;
         S_NO_RD:  rd_addr = b_ff;
         S_SC_RD:  rd_addr = s_ff;
         S_SH_RD:  rd_addr = s_ff;
         S_RN_RD:  rd_addr = s_inc;
         S_SOC_RD: rd_addr = s_ff;
         S_SO_RD:  rd_addr = s_inc;
         S_SQ_RD:  rd_addr = quot_ff;
         S_FX_RD:  rd_addr = found_ff;
         default:  rd_addr = s_ff;
      endcase
   end

   always_comb begin
      state_in = state_ff;
      op_in    = op_ff;
      q_in     = q_ff;
      r_in     = r_ff;
      count_in = count_ff;
      t_in     = t_ff;
      b_in     = b_ff;
      s_in     = s_ff;
      start_in = start_ff;
      first_in = first_ff;
      cur_in   = cur_ff;
      nx_in    = nx_ff;
      quot_in  = quot_ff;
      found_in = found_ff;
      head_in  = head_ff;
      ans_in   = ans_ff;
      clr_in   = clr_ff;
      wr_en    = 1'b0;
      wr_addr  = s_ff;
      wr_data  = '0;
      ent      = '0;
      prev     = rd;
      upd      = nx_ff;

      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_ans_in   = rsp_ans_ff;
      rsp_cnt_in   = rsp_cnt_ff;

      unique case (state_ff)
         S_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = clr_ff;
            wr_data = '0;
            clr_in  = clr_ff + IW'(1);
            if (clr_ff == IW'(TSIZE - 1)) begin
               state_in = S_IDLE;
            end
         end

         S_IDLE: begin
            if (req_tvalid) begin
               op_in = req_tuser;
               q_in  = req_tdata[RBITS +: QBITS];
               r_in  = req_tdata[RBITS-1:0];
               priority if (req_tuser == OP_INSERT) begin
                  if (count_ff >= CW'(TSIZE)) begin
                     ans_in   = 1'b0;
                     state_in = S_DONE;
                  end else begin
                     state_in = S_T_RD;
                  end
               end else if (req_tuser == OP_LOOKUP) begin
                  state_in = S_T_RD;
               end else if (req_tuser == OP_REMOVE) begin
                  if (|(req_tdata >> (QBITS + RBITS))) begin
                     ans_in   = 1'b0;
                     state_in = S_DONE;
                  end else begin
                     state_in = S_T_RD;
                  end
               end else begin
                  ans_in   = 1'b0;
                  state_in = S_DONE;
               end
            end
         end

         S_T_RD: state_in = S_T;

         S_T: begin
            t_in = rd;
            b_in = q_ff;
            priority if (op_ff == OP_INSERT) begin
               if (is_empty(rd)) begin
                  wr_en    = 1'b1;
                  wr_addr  = q_ff;
                  ent      = '0;
                  ent[EW-1:FLAG_BITS] = r_ff;
                  ent[FLAG_OCC] = 1'b1;
                  wr_data  = ent;
                  count_in = count_ff + CW'(1);
                  ans_in   = 1'b1;
                  state_in = S_DONE;
               end else begin
                  if (!rd[FLAG_OCC]) begin
                     wr_en   = 1'b1;
                     wr_addr = q_ff;
                     ent     = rd;
                     ent[FLAG_OCC] = 1'b1;
                     wr_data = ent;
                  end
                  state_in = S_LB_RD;
               end
            end else if (op_ff == OP_LOOKUP) begin
               if (!rd[FLAG_OCC]) begin
                  ans_in   = 1'b0;
                  state_in = S_DONE;
               end else begin
                  state_in = S_LB_RD;
               end
            end else begin
               if (!rd[FLAG_OCC] || count_ff == '0) begin
                  ans_in   = 1'b1;
                  state_in = S_DONE;
               end else begin
                  state_in = S_LB_RD;
               end
            end
         end

         // walk back to the cluster head
         S_LB_RD: state_in = S_LB;
         S_LB: begin
            if (rd[FLAG_SHIFT]) begin
               b_in     = b_ff - IW'(1);
               state_in = S_LB_RD;
            end else begin
               s_in     = b_ff;
               state_in = S_LR;
            end
         end

         // step runs and occupied slots together until b reaches q
         S_LR: begin
            if (b_ff == q_ff) begin
               start_in = s_ff;
               first_in = 1'b1;
               if (op_ff == OP_INSERT && !t_ff[FLAG_OCC]) begin
                  ent = '0;
                  ent[EW-1:FLAG_BITS] = r_ff;
                  ent[FLAG_SHIFT] = (s_ff != q_ff);
                  cur_in   = ent;
                  state_in = S_SH_RD;
               end else begin
                  state_in = S_SC_RD;
               end
            end else begin
               s_in     = s_inc;
               state_in = S_NR_RD;
            end
         end

         S_NR_RD: state_in = S_NR;
         S_NR: begin
            if (rd[FLAG_CONT]) begin
               s_in     = s_inc;
               state_in = S_NR_RD;
            end else begin
               b_in     = b_ff + IW'(1);
               state_in = S_NO_RD;
            end
         end

         S_NO_RD: state_in = S_NO;
         S_NO: begin
            if (!rd[FLAG_OCC]) begin
               b_in     = b_ff + IW'(1);
               state_in = S_NO_RD;
            end else begin
               state_in = S_LR;
            end
         end

         // scan the run for the remainder
         S_SC_RD: state_in = S_SC;
         S_SC: begin
            if ((first_ff || rd[FLAG_CONT]) && rd[EW-1:FLAG_BITS] < r_ff) begin
               s_in     = s_inc;
               first_in = 1'b0;
               state_in = S_SC_RD;
            end else if ((first_ff || rd[FLAG_CONT]) && rd[EW-1:FLAG_BITS] == r_ff) begin
               priority if (op_ff == OP_REMOVE) begin
                  found_in = s_ff;
                  head_in  = is_run_head(rd);
                  state_in = S_RN_RD;
               end else begin
                  ans_in   = 1'b1;
                  state_in = S_DONE;
               end
            end else begin
               // end of run or a larger remainder
               priority if (op_ff == OP_INSERT) begin
                  ent = '0;
                  ent[EW-1:FLAG_BITS] = r_ff;
                  if (s_ff == start_ff) begin
                     wr_en   = 1'b1;
                     wr_addr = s_ff;
                     prev    = rd;
                     prev[FLAG_CONT] = 1'b1;
                     wr_data = prev;
                  end else begin
                     ent[FLAG_CONT] = 1'b1;
                  end
                  ent[FLAG_SHIFT] = (s_ff != q_ff);
                  cur_in   = ent;
                  state_in = S_SH_RD;
               end else if (op_ff == OP_LOOKUP) begin
                  ans_in   = 1'b0;
                  state_in = S_DONE;
               end else begin
                  ans_in   = 1'b1;
                  state_in = S_DONE;
               end
            end
         end

         // shift the rest of the cluster one slot right
         S_SH_RD: state_in = S_SH;
         S_SH: begin
            ent  = cur_ff;
            prev = rd;
            if (!is_empty(rd)) begin
               prev[FLAG_SHIFT] = 1'b1;
               if (rd[FLAG_OCC]) begin
                  ent[FLAG_OCC]  = 1'b1;
                  prev[FLAG_OCC] = 1'b0;
               end
            end
            wr_en   = 1'b1;
            wr_addr = s_ff;
            wr_data = ent;
            cur_in  = prev;
            s_in    = s_inc;
            if (is_empty(rd)) begin
               count_in = count_ff + CW'(1);
               ans_in   = 1'b1;
               state_in = S_DONE;
            end else begin
               state_in = S_SH_RD;
            end
         end

         // remove: drop the occupied mark when the run empties
         S_RN_RD: state_in = S_RN;
         S_RN: begin
            if (head_ff && !rd[FLAG_CONT]) begin
               wr_en   = 1'b1;
               wr_addr = q_ff;
               ent     = t_ff;
               ent[FLAG_OCC] = 1'b0;
               wr_data = ent;
            end
            quot_in  = q_ff;
            state_in = S_SOC_RD;
         end

         S_SOC_RD: state_in = S_SOC;
         S_SOC: begin
            cur_in   = rd;
            state_in = S_SO_RD;
         end

         // slide the cluster one slot left
         S_SO_RD: state_in = S_SO;
         S_SO: begin
            nx_in = rd;
            if (is_empty(rd) || is_cluster_head(rd) || s_inc == found_ff) begin
               wr_en   = 1'b1;
               wr_addr = s_ff;
               wr_data = '0;
               if (head_ff) begin
                  state_in = S_FX_RD;
               end else begin
                  count_in = count_ff - CW'(1);
                  ans_in   = 1'b1;
                  state_in = S_DONE;
               end
            end else if (is_run_head(rd)) begin
               quot_in  = quot_ff + IW'(1);
               state_in = S_SQ_RD;
            end else begin
               state_in = S_SOW;
            end
         end

         S_SQ_RD: state_in = S_SQ;
         S_SQ: begin
            if (!rd[FLAG_OCC]) begin
               quot_in  = quot_ff + IW'(1);
               state_in = S_SQ_RD;
            end else begin
               state_in = S_SOW;
            end
         end

         S_SOW: begin
            upd = nx_ff;
            if (is_run_head(nx_ff) && cur_ff[FLAG_OCC] && quot_ff == s_ff) begin
               upd[FLAG_SHIFT] = 1'b0;
            end
            upd[FLAG_OCC] = cur_ff[FLAG_OCC];
            wr_en    = 1'b1;
            wr_addr  = s_ff;
            wr_data  = upd;
            s_in     = s_inc;
            cur_in   = nx_ff;
            state_in = S_SO_RD;
         end

         // fix flags of the slot that took the removed run head
         S_FX_RD: state_in = S_FX;
         S_FX: begin
            ent = rd;
            ent[FLAG_CONT] = 1'b0;
            if (found_ff == q_ff && is_run_head(ent)) begin
               ent[FLAG_SHIFT] = 1'b0;
            end
            wr_en    = 1'b1;
            wr_addr  = found_ff;
            wr_data  = ent;
            count_in = count_ff - CW'(1);
            ans_in   = 1'b1;
            state_in = S_DONE;
         end

         S_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_ans_in   = ans_ff;
               rsp_cnt_in   = COUNT_W'(count_ff);
               state_in     = S_IDLE;
            end
         end

         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff      <= op_in;
      q_ff       <= q_in;
      r_ff       <= r_in;
      t_ff       <= t_in;
      b_ff       <= b_in;
      s_ff       <= s_in;
      start_ff   <= start_in;
      first_ff   <= first_in;
      cur_ff     <= cur_in;
      nx_ff      <= nx_in;
      quot_ff    <= quot_in;
      found_ff   <= found_in;
      head_ff    <= head_in;
      ans_ff     <= ans_in;
      rsp_ans_ff <= rsp_ans_in;
      rsp_cnt_ff <= rsp_cnt_in;
   end

endmodule

// ===== rtl/qfe_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qfe_checker
// Port-level checks for the quotient filter engine, bound to the top level.
// ----------------------------------------------------------------------------
module qfe_checker
   import qfe_pkg::*;
#(
   parameter int QBITS = 10
) (
   input logic              clock,
   input logic              reset,
   input logic              req_tvalid,
   input logic              req_tready,
   input logic [HASH_W-1:0] req_tdata,
   input logic [OP_W-1:0]   req_tuser,
   input logic              rsp_tvalid,
   input logic              rsp_tready,
   input logic [RSP_W-1:0]  rsp_tdata
);

   // one request at a time: ready drops after every transaction
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("qfe: accepted a second request back to back");

   // reset starts the clearing pass and empties the output register
   assert property (@(posedge clock)
      reset |=> !req_tready && !rsp_tvalid)
      else $error("qfe: not quiet after reset");

   // entry count never exceeds the table size
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[COUNT_W:1] <= COUNT_W'(1 << QBITS))
      else $error("qfe: entry count beyond table size");

   // a stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("qfe: stalled result changed");

endmodule

bind quotient_filter_engine qfe_checker #(.QBITS(QBITS)) u_qfe_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tdata  (req_tdata),
   .req_tuser  (req_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the quotient filter engine: an in-bench slot table
// predicts answer and entry count for each insert, lookup and remove; random
// traffic, partly narrow, builds long clusters; a directed fill tests a full table.
// ----------------------------------------------------------------------------
module tb_top;
   import qfe_pkg::*;

   localparam int QB = 10;
   localparam int RB = 8;
   localparam int SLOTS = 1 << QB;
   localparam int LIMIT = 100_000_000;

   typedef struct packed {
      op_type      op;
      logic [63:0] hash;
   } request_type;

   typedef struct packed {
      logic        answer;
      logic [10:0] count;
   } outcome_type;

   logic clock = 0;
   logic reset = 1;
   logic req_tvalid = 0;
   logic req_tready;
   logic [HASH_W-1:0] req_tdata = '0;
   logic [OP_W-1:0] req_tuser = OP_INSERT;
   logic rsp_tvalid;
   logic rsp_tready = 0;
   logic [RSP_W-1:0] rsp_tdata;

   quotient_filter_engine #(.QBITS(QB), .RBITS(RB)) dut (.*);

   always begin
      #6 clock = 1;
      #6 clock = 0;
   end

   // predictor state: slot = {remainder, shifted, continuation, occupied}
   logic [RB+2:0] slots [SLOTS];
   int unsigned   stored;
   request_type   pending_reqs[$];
   outcome_type   expected_outcomes[$];
   int            errors = 0;
   int            n_rsp = 0, n_ins = 0, n_look = 0, n_rem = 0;
   longint        cycles = 0;
   bit            stim_done = 0;
   bit            calm = 0;
   int            hold_off = 0;
   bit            hold_done = 0;

   function automatic logic [QB-1:0] nxt(logic [QB-1:0] i);
      return i + QB'(1);
   endfunction

   function automatic logic [QB-1:0] prv(logic [QB-1:0] i);
      return i - QB'(1);
   endfunction

   function automatic bit is_empty(logic [RB+2:0] e);
      return e[2:0] == 3'b000;
   endfunction

   function automatic bit is_cluster_head(logic [RB+2:0] e);
      return e[FLAG_OCC] && !e[FLAG_CONT] && !e[FLAG_SHIFT];
   endfunction

   function automatic bit is_run_head(logic [RB+2:0] e);
      return !e[FLAG_CONT] && (e[FLAG_OCC] || e[FLAG_SHIFT]);
   endfunction

   function automatic logic [QB-1:0] next_occ(logic [QB-1:0] b);
      int k;
      k = 0;
      do begin
         b = nxt(b); k++;
      end while (!slots[b][FLAG_OCC] && k < SLOTS);
      return b;
   endfunction

   function automatic logic [QB-1:0] run_start(logic [QB-1:0] q);
      logic [QB-1:0] b, s;
      int k;
      b = q; k = 0;
      while (slots[b][FLAG_SHIFT] && k < SLOTS) begin
         b = prv(b); k++;
      end
      s = b; k = 0;
      while (b != q && k < SLOTS) begin
         do s = nxt(s); while (slots[s][FLAG_CONT]);
         b = next_occ(b);
         k++;
      end
      return s;
   endfunction

   function automatic void push_right(logic [QB-1:0] s, logic [RB+2:0] e);
      logic [RB+2:0] cur, old;
      bit empty;
      int k;
      cur = e; k = 0;
      do begin
         old = slots[s];
         empty = is_empty(old);
         if (!empty) begin
            old[FLAG_SHIFT] = 1;
            if (old[FLAG_OCC]) begin
               cur[FLAG_OCC] = 1; old[FLAG_OCC] = 0;
            end
         end
         slots[s] = cur;
         cur = old;
         s = nxt(s); k++;
      end while (!empty && k < SLOTS);
   endfunction

   function automatic bit insert_hash(logic [63:0] hash);
      logic [QB-1:0] q, st, s;
      logic [RB-1:0] r;
      logic [RB+2:0] t, e;
      int k;
      if (stored >= SLOTS) return 0;
      q = hash[RB +: QB];
      r = hash[RB-1:0];
      t = slots[q];
      e = {r, 3'b000};
      if (is_empty(t)) begin
         slots[q] = {r, 3'b001};
         stored++;
         return 1;
      end
      if (!t[FLAG_OCC]) slots[q][FLAG_OCC] = 1;
      st = run_start(q);
      s = st;
      if (t[FLAG_OCC]) begin
         k = 0;
         do begin
            if (slots[s][RB+2:3] == r) return 1;
            if (slots[s][RB+2:3] > r) break;
            s = nxt(s); k++;
         end while (slots[s][FLAG_CONT] && k < SLOTS);
         if (s == st) slots[st][FLAG_CONT] = 1;
         else e[FLAG_CONT] = 1;
      end
      if (s != q) e[FLAG_SHIFT] = 1;
      push_right(s, e);
      stored++;
      return 1;
   endfunction

   function automatic bit lookup_hash(logic [63:0] hash);
      logic [QB-1:0] q, s;
      logic [RB-1:0] r;
      int k;
      q = hash[RB +: QB];
      r = hash[RB-1:0];
      if (!slots[q][FLAG_OCC]) return 0;
      s = run_start(q); k = 0;
      do begin
         if (slots[s][RB+2:3] == r) return 1;
         if (slots[s][RB+2:3] > r) return 0;
         s = nxt(s); k++;
      end while (slots[s][FLAG_CONT] && k < SLOTS);
      return 0;
   endfunction

   function automatic void pull_left(logic [QB-1:0] s, logic [QB-1:0] quot);
      logic [RB+2:0] cur, nx, upd;
      logic [QB-1:0] sp, home;
      bit cocc;
      cur = slots[s]; sp = nxt(s); home = s;
      forever begin
         nx = slots[sp]; upd = nx;
         cocc = cur[FLAG_OCC];
         if (is_empty(nx) || is_cluster_head(nx) || sp == home) begin
            slots[s] = '0;
            return;
         end
         if (is_run_head(nx)) begin
            quot = next_occ(quot);
            if (cocc && quot == s) upd[FLAG_SHIFT] = 0;
         end
         upd[FLAG_OCC] = cocc;
         slots[s] = upd;
         s = sp; sp = nxt(sp); cur = nx;
      end
   endfunction

   function automatic bit remove_hash(logic [63:0] hash);
      logic [QB-1:0] q, s;
      logic [RB-1:0] r, rem;
      logic [RB+2:0] t, kill, u;
      bit head;
      int k;
      if (hash[63:QB+RB] != 0) return 0;
      q = hash[RB +: QB];
      r = hash[RB-1:0];
      t = slots[q];
      if (!t[FLAG_OCC] || stored == 0) return 1;
      s = run_start(q); k = 0; rem = 0;
      do begin
         rem = slots[s][RB+2:3];
         if (rem == r) break;
         if (rem > r) return 1;
         s = nxt(s); k++;
      end while (slots[s][FLAG_CONT] && k < SLOTS);
      if (rem != r) return 1;
      kill = (s == q) ? t : slots[s];
      head = is_run_head(kill);
      if (head && !slots[nxt(s)][FLAG_CONT]) begin
         t[FLAG_OCC] = 0;
         slots[q] = t;
      end
      pull_left(s, q);
      if (head) begin
         u = slots[s];
         u[FLAG_CONT] = 0;
         if (s == q && is_run_head(u)) u[FLAG_SHIFT] = 0;
         slots[s] = u;
      end
      stored--;
      return 1;
   endfunction

   function automatic outcome_type apply_request(request_type rq);
      outcome_type o;
      case (rq.op)
         OP_INSERT: begin
            o.answer = insert_hash(rq.hash); n_ins++;
         end
         OP_LOOKUP: begin
            o.answer = lookup_hash(rq.hash); n_look++;
         end
         OP_REMOVE: begin
            o.answer = remove_hash(rq.hash); n_rem++;
         end
         default: o.answer = 0;
      endcase
      o.count = stored[10:0];
      return o;
   endfunction

   // driver
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            expected_outcomes.push_back(apply_request('{req_tuser, req_tdata}));
            void'(pending_reqs.pop_front());
         end
         if ((!req_tvalid || req_tready) || 1) begin
            if (req_tvalid && !req_tready) begin
               // keep offering the same transaction
            end else if (pending_reqs.size() > 0 &&
                         (calm || $urandom_range(99) >= 15)) begin
               req_tvalid <= 1;
               req_tdata  <= pending_reqs[0].hash;
               req_tuser  <= pending_reqs[0].op;
            end else begin
               req_tvalid <= 0;
            end
         end
      end
   end

   // long receiver stall, counted in cycles
   always @(posedge clock) begin
      if (!reset) begin
         if (!hold_done && n_rsp >= 300) begin
            hold_done <= 1;
            hold_off <= 2000;
         end else if (hold_off > 0) begin
            hold_off <= hold_off - 1;
         end
      end
   end

   // monitor and receiver
   always @(posedge clock) begin
      outcome_type exp_o;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            n_rsp++;
            if (expected_outcomes.size() == 0) begin
               $error("response with no request outstanding");
               errors++;
            end else begin
               exp_o = expected_outcomes.pop_front();
               if (rsp_tdata[0] !== exp_o.answer) begin
                  $error("answer: expected %0d, got %0d", exp_o.answer, rsp_tdata[0]);
                  errors++;
               end
               if (rsp_tdata[11:1] !== exp_o.count) begin
                  $error("entry_count: expected %0d, got %0d", exp_o.count,
                         rsp_tdata[11:1]);
                  errors++;
               end
            end
         end
         if (hold_off > 0) begin
            rsp_tready <= 0;
         end else begin
            rsp_tready <= calm || $urandom_range(99) >= 15;
         end
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("RESULT: ERROR");
         $finish;
      end
   end

   function automatic logic [63:0] near_hash(int unsigned qspan);
      logic [63:0] h;
      h = '0;
      h[RB-1:0] = RB'($urandom_range(2 ** RB - 1));
      h[RB +: QB] = QB'($urandom_range(qspan));
      return h;
   endfunction

   initial begin
      request_type rq;
      int i;
      for (i = 0; i < SLOTS; i++) slots[i] = '0;
      stored = 0;
      // directed: extremes, wrap at the top slot, duplicates, clusters
      pending_reqs.push_back('{OP_LOOKUP, 64'd0});
      pending_reqs.push_back('{OP_REMOVE, 64'd0});
      pending_reqs.push_back('{OP_INSERT, 64'd0});
      pending_reqs.push_back('{OP_INSERT, 64'd0});
      pending_reqs.push_back('{OP_INSERT, 64'hFF});
      pending_reqs.push_back('{OP_INSERT, 64'h80});
      pending_reqs.push_back('{OP_INSERT, 64'h1_05});
      pending_reqs.push_back('{OP_INSERT, 64'h3FF_FF});
      pending_reqs.push_back('{OP_INSERT, 64'h3FF_10});
      pending_reqs.push_back('{OP_INSERT, 64'h3FF_20});
      pending_reqs.push_back('{OP_INSERT, 64'hFFFF_FFFF_FFFF_FFFF});
      pending_reqs.push_back('{OP_LOOKUP, 64'hFFFF_FFFF_FFFF_FFFF});
      pending_reqs.push_back('{OP_LOOKUP, 64'h3FF_11});
      pending_reqs.push_back('{OP_LOOKUP, 64'h80});
      pending_reqs.push_back('{OP_REMOVE, 64'hFFFF_FFFF_FFFF_FFFF});
      pending_reqs.push_back('{OP_REMOVE, 64'h4_0000});
      pending_reqs.push_back('{OP_REMOVE, 64'h3FF_FF});
      pending_reqs.push_back('{OP_REMOVE, 64'h0});
      pending_reqs.push_back('{OP_REMOVE, 64'h0});
      pending_reqs.push_back('{OP_REMOVE, 64'h1_06});
      pending_reqs.push_back('{OP_LOOKUP, 64'hFF});
      pending_reqs.push_back('{2'd3, 64'h1_05});
      // random: a narrow quotient range packs long clusters
      for (i = 0; i < 900; i++) begin
         rq.hash = near_hash(i % 3 == 0 ? 40 : SLOTS - 1);
         if ($urandom_range(9) == 0) begin
            rq.hash[63:32] = $urandom;
            rq.hash[31:QB+RB] = (32-QB-RB)'($urandom);
         end
         case ($urandom_range(9))
            0, 1, 2, 3, 4: rq.op = OP_INSERT;
            5, 6:          rq.op = OP_LOOKUP;
            7, 8:          rq.op = OP_REMOVE;
            default:       rq.op = 2'd3;
         endcase
         pending_reqs.push_back(rq);
      end
      // fill the table to full, then drain some
      for (i = 0; i < SLOTS + 40; i++)
         pending_reqs.push_back('{OP_INSERT, 64'(i)});
      for (i = 0; i < 60; i++)
         pending_reqs.push_back('{OP_REMOVE, 64'(i * 7)});
      repeat (12) @(posedge clock);
      reset <= 0;
      wait (cycles > 3000);
      @(posedge clock) calm <= 1;
      wait (cycles > 8000);
      @(posedge clock) calm <= 0;
      wait (pending_reqs.size() == 0 && !req_tvalid);
      wait (expected_outcomes.size() == 0);
      repeat (100) @(posedge clock);
      $display("covered %0d inserts, %0d lookups, %0d removes; %0d responses checked",
               n_ins, n_look, n_rem, n_rsp);
      $display("final entry count %0d, long receiver stall exercised", stored);
      if (errors == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/qfe_pkg.sv
rtl/qfe_slot_ram.sv
rtl/quotient_filter_engine.sv
rtl/qfe_checker.sv
verif/tb_top.sv
